@@ rtl/core/ppa_pkg.sv @@
// ============================================================================
// ppa_pkg
// Shared types, Q30 angle constants and the arctangent table of the
// point-pair angle pipeline.
// ============================================================================
package ppa_pkg;

    // Datapath width of the rotation vector (guard scaling puts the input at bit 60)
    localparam int XW        = 64;
    localparam int GUARD_TOP = 60;

    // Angle accumulator: signed Q30 radians, covers -pi/2 .. 3*pi/2 and more
    localparam int ZW        = 35;
    localparam int Q30_FRAC  = 30;
    localparam int ATAN_W    = 30;
    localparam int OUT_W     = 16;

    localparam logic [ZW-1:0] Q30_PI            = 35'd3373259426;
    localparam logic [ZW-1:0] Q30_HALF_PI       = 35'd1686629713;
    localparam logic [ZW-1:0] Q30_THREE_HALF_PI = 35'd5059889139;
    localparam logic [ZW-1:0] Q30_TWO_PI        = 35'd6746518852;

    // Per-stage control that travels with each transaction
    typedef struct packed {
        logic valid;
        logic bypass;   // axis-aligned vector: angle already final, micro-rotations leave it unchanged
    } t_ctl;

    // atan(2^-idx) in Q30 radians, rounded to nearest
    function automatic logic [ATAN_W-1:0] atan_q30(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048576;
            5'd11:   v = 30'd524288;
            5'd12:   v = 30'd262144;
            5'd13:   v = 30'd131072;
            5'd14:   v = 30'd65536;
            5'd15:   v = 30'd32768;
            5'd16:   v = 30'd16384;
            5'd17:   v = 30'd8192;
            5'd18:   v = 30'd4096;
            5'd19:   v = 30'd2048;
            5'd20:   v = 30'd1024;
            5'd21:   v = 30'd512;
            5'd22:   v = 30'd256;
            5'd23:   v = 30'd128;
            5'd24:   v = 30'd64;
            5'd25:   v = 30'd32;
            5'd26:   v = 30'd16;
            5'd27:   v = 30'd8;
            5'd28:   v = 30'd4;
            5'd29:   v = 30'd2;
            5'd30:   v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Half of one output step, in Q30
    function automatic logic [ZW-1:0] round_half(input int drop);
        return ZW'(1) << (drop - 1);
    endfunction

    // 2*pi rounded to the output step
    function automatic logic [ZW-1:0] two_pi_out(input int drop);
        logic [ZW-1:0] s;
        s = Q30_TWO_PI + round_half(drop);
        return s >> drop;
    endfunction

endpackage

@@ rtl/core/ppa_pre.sv @@
// ============================================================================
// ppa_pre
// Front end: forms the coordinate differences, folds the left half-plane
// onto the right one and seeds the angle accumulator. Two register stages.
// ============================================================================
module ppa_pre import ppa_pkg::*; #(
    parameter int CW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [CW-1:0] i_first_x,
    input  logic signed [CW-1:0] i_first_y,
    input  logic signed [CW-1:0] i_second_x,
    input  logic signed [CW-1:0] i_second_y,
    output t_ctl                 o_ctl,
    input  logic                 i_ready,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [ZW-1:0] o_z
);

    localparam int GUARD = GUARD_TOP - CW;

    logic                 r_v1;
    logic signed [CW:0]   r_dx;
    logic signed [CW:0]   r_dy;
    logic                 w_rdy1;
    logic                 w_rdy2;

    t_ctl                 r_ctl;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;

    logic signed [CW:0]   n_dx;
    logic signed [CW:0]   n_dy;
    logic signed [XW-1:0] w_dx_ext;
    logic signed [XW-1:0] w_dy_ext;
    logic                 w_dx_neg;
    logic                 w_dx_zero;
    logic                 w_dy_zero;
    t_ctl                 n_ctl;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    logic [ZW-1:0]        n_z;

    assign w_rdy2  = !r_ctl.valid || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // Stage 1: exact differences, one bit wider than the coordinates
    assign n_dx = {i_second_x[CW-1], i_second_x} - {i_first_x[CW-1], i_first_x};
    assign n_dy = {i_second_y[CW-1], i_second_y} - {i_first_y[CW-1], i_first_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
    end

    // Stage 2: classify, rotate by pi when dx is negative, scale up
    always_comb begin
        w_dx_neg  = r_dx[CW];
        w_dx_zero = (r_dx == '0);
        w_dy_zero = (r_dy == '0);
        w_dx_ext  = {{(XW-CW-1){r_dx[CW]}}, r_dx};
        w_dy_ext  = {{(XW-CW-1){r_dy[CW]}}, r_dy};
        n_x       = (w_dx_neg ? -w_dx_ext : w_dx_ext) <<< GUARD;
        n_y       = (w_dx_neg ? -w_dy_ext : w_dy_ext) <<< GUARD;
        n_ctl.valid  = r_v1;
        n_ctl.bypass = w_dx_zero || w_dy_zero;
        if (w_dx_zero) begin
            n_z = r_dy[CW] ? Q30_THREE_HALF_PI : Q30_HALF_PI;
        end else if (w_dx_neg) begin
            n_z = Q30_PI;
        end else begin
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (w_rdy2) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= $signed(n_z);
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

@@ rtl/core/ppa_cordic_stage.sv @@
// ============================================================================
// ppa_cordic_stage
// One vectoring micro-rotation by atan(2^-IDX), registered.
// ============================================================================
module ppa_cordic_stage import ppa_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctl                 i_ctl,
    output logic                 o_ready,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output t_ctl                 o_ctl,
    input  logic                 i_ready,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [ZW-1:0] o_z
);

    localparam logic [ATAN_W-1:0] ATAN = atan_q30(5'(IDX));
    localparam logic signed [ZW-1:0] ATAN_Z = $signed({{(ZW-ATAN_W){1'b0}}, ATAN});

    t_ctl                 r_ctl;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic                 w_rdy;
    logic signed [XW-1:0] w_xs;
    logic signed [XW-1:0] w_ys;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    logic signed [ZW-1:0] n_z;

    assign w_rdy   = !r_ctl.valid || i_ready;
    assign o_ready = w_rdy;

    // Rotate toward the x axis; hold the angle of an axis-aligned vector
    always_comb begin
        w_xs = i_x >>> IDX;
        w_ys = i_y >>> IDX;
        if (i_y > 0) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_ctl.bypass ? i_z : i_z + ATAN_Z;
        end else begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_ctl.bypass ? i_z : i_z - ATAN_Z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (w_rdy) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_ctl.valid) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

@@ rtl/core/ppa_post.sv @@
// ============================================================================
// ppa_post
// Back end: wraps the Q30 angle into [0, 2*pi) and rounds it to the output
// step. Two register stages, the second being the output register.
// ============================================================================
module ppa_post import ppa_pkg::*; #(
    parameter int FRAC = 13
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctl                 i_ctl,
    output logic                 o_ready,
    input  logic signed [ZW-1:0] i_z,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [OUT_W-1:0]     o_angle
);

    localparam int            DROP = Q30_FRAC - FRAC;
    localparam logic [ZW-1:0] HALF = round_half(DROP);
    localparam logic [ZW-1:0] TPO  = two_pi_out(DROP);
    localparam logic [ZW-1:0] WRAP = Q30_TWO_PI + HALF;

    logic             r_va;
    logic [ZW-1:0]    r_a;
    logic             r_vb;
    logic [OUT_W-1:0] r_angle;
    logic             w_rdy_a;
    logic             w_rdy_b;
    logic [ZW-1:0]    n_a;
    logic [ZW-1:0]    w_sh;
    logic [ZW-1:0]    w_wr;

    assign w_rdy_b = !r_vb || i_ready;
    assign w_rdy_a = !r_va || w_rdy_b;
    assign o_ready = w_rdy_a;

    // Stage A: lift negative angles by 2*pi and add the rounding half step
    assign n_a = $unsigned(i_z) + (i_z[ZW-1] ? WRAP : HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (w_rdy_a) begin
            r_va <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_ctl.valid) begin
            r_a <= n_a;
        end
    end

    // Stage B: drop fraction bits, fold a full turn back to zero
    always_comb begin
        w_sh = r_a >> DROP;
        w_wr = (w_sh >= TPO) ? w_sh - TPO : w_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (w_rdy_b) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_b && r_va) begin
            r_angle <= w_wr[OUT_W-1:0];
        end
    end

    assign o_valid = r_vb;
    assign o_angle = r_angle;

endmodule

@@ rtl/core/point_pair_angle_atan2.sv @@
// Throughput: one transaction per cycle while the output sink is ready; every stage holds
// one item with its own valid bit. A stalled output backs up stage by stage, so empty
// stages still take new input.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
// ============================================================================
// point_pair_angle_atan2
// Direction angle from a first to a second point, atan2 of the differences
// by a pipelined vectoring CORDIC, unsigned fixed point in [0, 2*pi).
// ============================================================================
module point_pair_angle_atan2 import ppa_pkg::*; #(
    parameter int COORD_WIDTH     = 16,
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // first_x, first_y, second_x, second_y (COORD_WIDTH each), zero fill
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // angle (16)
    output logic [OUT_W-1:0]     m_axis_tdata
);

    localparam int CW = COORD_WIDTH;
    localparam int N  = CORDIC_STAGES;
    localparam logic [ZW-1:0] TPO = two_pi_out(Q30_FRAC - ANGLE_FRAC_BITS);

    t_ctl                 c_ctl [N+1];
    logic                 c_rdy [N+1];
    logic signed [XW-1:0] c_x   [N+1];
    logic signed [XW-1:0] c_y   [N+1];
    logic signed [ZW-1:0] c_z   [N+1];

    // Differences, half-plane fold and angle seed
    ppa_pre #(
        .CW (CW)
    ) u_pre (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_first_x  (s_axis_tdata[CW-1:0]),
        .i_first_y  (s_axis_tdata[2*CW-1:CW]),
        .i_second_x (s_axis_tdata[3*CW-1:2*CW]),
        .i_second_y (s_axis_tdata[4*CW-1:3*CW]),
        .o_ctl      (c_ctl[0]),
        .i_ready    (c_rdy[0]),
        .o_x        (c_x[0]),
        .o_y        (c_y[0]),
        .o_z        (c_z[0])
    );

    // Micro-rotation chain
    for (genvar k = 0; k < N; k++) begin : g_stage
        ppa_cordic_stage #(
            .IDX (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (c_ctl[k]),
            .o_ready (c_rdy[k]),
            .i_x     (c_x[k]),
            .i_y     (c_y[k]),
            .i_z     (c_z[k]),
            .o_ctl   (c_ctl[k+1]),
            .i_ready (c_rdy[k+1]),
            .o_x     (c_x[k+1]),
            .o_y     (c_y[k+1]),
            .o_z     (c_z[k+1])
        );
    end

    // Wrap, round and output register
    ppa_post #(
        .FRAC (ANGLE_FRAC_BITS)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (c_ctl[N]),
        .o_ready (c_rdy[N]),
        .i_z     (c_z[N]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_angle (m_axis_tdata)
    );

    // A ready sink must open the whole ready chain back to the input
    a_ready_chain: assert property (@(posedge i_clk)
        m_axis_tready |-> s_axis_tready)
        else $error("ready chain blocked while the output sink is ready");

    // Axis-aligned vectors carry one of the four exact angles
    a_bypass_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_ctl[0].valid && c_ctl[0].bypass) |->
            (c_z[0] == $signed(Q30_HALF_PI) || c_z[0] == $signed(Q30_THREE_HALF_PI) ||
             c_z[0] == $signed(Q30_PI) || c_z[0] == '0))
        else $error("axis-aligned vector seeded with a wrong angle");

    // Folded vectors entering the rotation chain lie in the right half-plane
    a_fold_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_ctl[0].valid && !c_ctl[0].bypass) |-> (c_x[0] > 0))
        else $error("rotation chain entered with non-positive x");

    // Result stays below a full turn whenever it fits the field
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((TPO > ZW'(2**OUT_W - 1)) || (ZW'(m_axis_tdata) < TPO)))
        else $error("output angle not wrapped into one turn");

endmodule

@@ tb/point_pair_angle_atan2_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// point_pair_angle_atan2_tb
// Streams point pairs into the angle pipeline and checks every returned
// angle against a bit-true CORDIC vectoring predictor, with bursty input
// and a receiver that stalls on its own changing pattern.
// ============================================================================
module point_pair_angle_atan2_tb;

    localparam int  COORD_W     = 16;
    localparam int  FRAC_BITS   = 13;
    localparam int  STAGES      = 16;
    localparam int  GUARD       = 60 - COORD_W;
    localparam int  DROP        = 30 - FRAC_BITS;
    localparam int  DATA_W      = ((4 * COORD_W + 7) / 8) * 8;
    localparam int  RANDOM_ITEMS = 1950;
    localparam int  DRAIN_CYCLES = 40;

    localparam longint PI_Q30         = 64'sd3373259426;
    localparam longint HALF_PI_Q30    = 64'sd1686629713;
    localparam longint THREE_HALF_Q30 = 64'sd5059889139;
    localparam longint TWO_PI_Q30     = 64'sd6746518852;

    // Micro-rotation angles atan(2^-i), Q30 radians
    localparam longint ROT_ANGLE [0:15] = '{
        843314857, 497837829, 263043837, 133525159,
        67021687, 33543516, 16775851, 8388437,
        4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768
    };

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_ALTERNATE
    } t_ready_mode;

    // ------------------------------------------------------------------------
    // Expected-angle tracker: predicts each angle and checks results in order
    // ------------------------------------------------------------------------
    class angle_tracker;
        logic [15:0] expected_angles [$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Bit-true direction angle of (sx-fx, sy-fy)
        function logic [15:0] predict_angle(t_coord fx, t_coord fy, t_coord sx, t_coord sy);
            longint dx, dy, x, y, xs, ys, acc, half, wrap_at, r;
            dx = longint'(sx) - longint'(fx);
            dy = longint'(sy) - longint'(fy);
            if (dx == 0) begin
                acc = (dy >= 0) ? HALF_PI_Q30 : THREE_HALF_Q30;
            end else if (dy == 0) begin
                acc = (dx > 0) ? 0 : PI_Q30;
            end else begin
                x   = dx <<< GUARD;
                y   = dy <<< GUARD;
                acc = 0;
                // fold left half-plane onto the right one
                if (x < 0) begin
                    x   = -x;
                    y   = -y;
                    acc = PI_Q30;
                end
                for (int i = 0; i < STAGES; i++) begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y > 0) begin
                        x   = x + ys;
                        y   = y - xs;
                        acc = acc + ROT_ANGLE[i];
                    end else begin
                        x   = x - ys;
                        y   = y + xs;
                        acc = acc - ROT_ANGLE[i];
                    end
                end
            end
            // wrap to [0, 2*pi) and round to the output step
            half    = longint'(1) <<< (DROP - 1);
            wrap_at = (TWO_PI_Q30 + half) >>> DROP;
            if (acc < 0) acc = acc + TWO_PI_Q30;
            r = (acc + half) >>> DROP;
            if (r >= wrap_at) r = r - wrap_at;
            if (r < 0) r = 0;
            return r[15:0];
        endfunction

        function void note_pair(logic [DATA_W-1:0] data);
            expected_angles.push_back(predict_angle(data[0*COORD_W +: COORD_W],
                                                    data[1*COORD_W +: COORD_W],
                                                    data[2*COORD_W +: COORD_W],
                                                    data[3*COORD_W +: COORD_W]));
        endfunction

        function void check_angle(logic [15:0] actual);
            logic [15:0] want;
            if (expected_angles.size() == 0) begin
                $error("angle: unexpected result %0d with nothing expected", actual);
                mismatches++;
            end else begin
                want = expected_angles.pop_front();
                if (actual !== want) begin
                    $error("angle mismatch: expected %0d, actual %0d", want, actual);
                    mismatches++;
                end
            end
        endfunction

        function int outstanding();
            return expected_angles.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata = '0;   // first_x, first_y, second_x, second_y
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;        // angle

    angle_tracker tracker = new();
    int           burst_left = 0;

    point_pair_angle_atan2 #(
        .COORD_WIDTH     (COORD_W),
        .ANGLE_FRAC_BITS (FRAC_BITS),
        .CORDIC_STAGES   (STAGES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock: 8 ns period
    always #4 i_clk = ~i_clk;

    // Record input transactions and check output transactions
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) tracker.note_pair(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) tracker.check_angle(m_axis_tdata);
        end
    end

    // Receiver back-pressure: switch to a randomly chosen pattern whenever the mode counter runs out
    t_ready_mode ready_mode = READY_ALWAYS;
    int          mode_left  = 0;
    logic        alt_phase  = 1'b0;

    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode <= t_ready_mode'($urandom_range(0, 3));
            mode_left  <= $urandom_range(64, 256);
        end else begin
            mode_left  <= mode_left - 1;
        end
        alt_phase <= ~alt_phase;
        case (ready_mode)
            READY_ALWAYS:    m_axis_tready <= 1'b1;
            READY_COIN:      m_axis_tready <= $urandom_range(0, 1);
            READY_SPARSE:    m_axis_tready <= ($urandom_range(0, 7) == 0);
            default:         m_axis_tready <= alt_phase;
        endcase
    end

    // Present one point pair and hold it until accepted; insert bursty gaps
    task automatic send_pair(t_coord fx, t_coord fy, t_coord sx, t_coord sy);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 30);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sy, sx, fy, fx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_coord any_coord();
        return t_coord'($urandom_range(0, 65535));
    endfunction

    function automatic t_coord edge_coord();
        case ($urandom_range(0, 6))
            0:       return -16'sd32768;
            1:       return -16'sd32767;
            2:       return -16'sd1;
            3:       return 16'sd0;
            4:       return 16'sd1;
            5:       return 16'sd32766;
            default: return 16'sd32767;
        endcase
    endfunction

    // Random pair, weighted toward the interesting geometry
    task automatic send_random_pair();
        t_coord fx, fy, sx, sy;
        int     kind, d;
        fx   = any_coord();
        fy   = any_coord();
        sx   = any_coord();
        sy   = any_coord();
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            // fully random
        end else if (kind < 55) begin
            // short vectors: coarse quantization near the axes
            fx = t_coord'(int'($urandom_range(0, 64000)) - 32000);
            fy = t_coord'(int'($urandom_range(0, 64000)) - 32000);
            sx = fx + t_coord'(int'($urandom_range(0, 16)) - 8);
            sy = fy + t_coord'(int'($urandom_range(0, 16)) - 8);
        end else if (kind < 65) begin
            sx = fx;                        // vertical
        end else if (kind < 75) begin
            sy = fy;                        // horizontal
        end else if (kind < 85) begin
            // diagonals
            d  = $urandom_range(1, 16000);
            fx = t_coord'(int'($urandom_range(0, 32000)) - 16000);
            fy = t_coord'(int'($urandom_range(0, 32000)) - 16000);
            sx = $urandom_range(0, 1) ? fx + t_coord'(d) : fx - t_coord'(d);
            sy = $urandom_range(0, 1) ? fy + t_coord'(d) : fy - t_coord'(d);
        end else if (kind < 95) begin
            fx = edge_coord();
            fy = edge_coord();
            sx = edge_coord();
            sy = edge_coord();
        end else begin
            sx = fx;                        // identical points
            sy = fy;
        end
        send_pair(fx, fy, sx, sy);
    endtask

    // Run limit
    initial begin
        #5_000_000;
        $display("point_pair_angle_atan2_tb NOT OK");
        $finish;
    end

    // Main sequence
    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, axes, coincident points, wrap neighborhoods
        send_pair(0, 0, 0, 0);
        send_pair(5, -7, 5, -7);
        send_pair(-32768, -32768, 32767, 32767);
        send_pair(32767, 32767, -32768, -32768);
        send_pair(-32768, 32767, 32767, -32768);
        send_pair(32767, -32768, -32768, 32767);
        send_pair(-32768, 0, 32767, 0);
        send_pair(32767, 0, -32768, 0);
        send_pair(0, -32768, 0, 32767);
        send_pair(0, 32767, 0, -32768);
        send_pair(0, 0, 1, 1);
        send_pair(0, 0, -1, 1);
        send_pair(0, 0, -1, -1);
        send_pair(0, 0, 1, -1);
        send_pair(0, 0, 32767, -1);
        send_pair(0, 0, 32767, 1);
        send_pair(0, 0, -32768, 1);
        send_pair(0, 0, -32768, -1);
        send_pair(0, 0, 1, -32768);
        send_pair(0, 0, -1, 32767);
        send_pair(-32768, 32767, 32767, 32766);
        send_pair(100, -200, -300, 400);

        repeat (RANDOM_ITEMS) send_random_pair();

        s_axis_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.mismatches == 0)
            $display("point_pair_angle_atan2_tb OK");
        else
            $display("point_pair_angle_atan2_tb NOT OK");
        $finish;
    end

endmodule
